// ===== rtl/core/fdr_pkg.sv =====
// ----------------------------------------------------------------------------
// fdr_pkg
// Shared types and constants for the fan duty ramp controller: payload
// layouts, register indexes and fixed duty limits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fdr_pkg;

    // Duty values are percent, 0..100
    localparam int unsigned DUTY_W  = 7;
    localparam int unsigned REQ_W   = 8;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [DUTY_W-1:0] DUTY_CAP  = 7'd100;
    localparam logic [REQ_W-1:0]  RAMP_STEP = 8'd3;

    // Register indexes on the configuration channel
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_DUTY    = 2'd0,
        CFG_MAX_DUTY    = 2'd1,
        CFG_RISE_PERIOD = 2'd2,
        CFG_FALL_PERIOD = 2'd3
    } t_cfg_idx;

    // Item kind carried on the slave tuser
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_SET  = 1'b1;

    // Slave tdata layout, highest bits first (padded to 16 bits)
    typedef struct packed {
        logic [5:0]       pad;
        logic             immediate;
        logic             keep_target;
        logic [REQ_W-1:0] target_percent;
    } t_in_data;

    // Master tdata layout, highest bits first
    typedef struct packed {
        logic              ramp_pending;
        logic              duty_written;
        logic [DUTY_W-1:0] target;
        logic [DUTY_W-1:0] duty;
    } t_out_data;

endpackage

// ===== rtl/core/fan_duty_ramp_controller.sv =====
// Each result is registered: in the output register, or in the skid entry while that is held.
// One item per cycle while the skid entry is empty; clamp, step and countdown are combinational.
// A two-entry output stage (result register plus skid) keeps tready high while
// a single result waits downstream.
// Reset (synchronous, active low): duty, target, countdown and armed clear,
// registers return to min 0, max 100, rise 500 ms, fall 2000 ms.
// ----------------------------------------------------------------------------
// fan_duty_ramp_controller
// Slew-rate limited fan duty: set-target requests and millisecond ticks step
// the driven duty toward a clamped target at configurable rise/fall periods.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fan_duty_ramp_controller
    import fdr_pkg::*;
#(
    parameter int unsigned PERIOD_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,  // target_percent[7:0], keep_target[8],
                                                // immediate[9], zero pad[15:10]
    input  logic                 s_axis_tuser,  // func: 0 tick, 1 set-target request
    // result stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [15:0]          m_axis_tdata   // duty[6:0], target[13:7],
                                                // duty_written[14], ramp_pending[15]
);

    // Width wide enough for both the period registers and the countdown
    localparam int unsigned CMP_W = (PERIOD_BITS > CFG_W) ? PERIOD_BITS : CFG_W;

    // Configuration registers
    logic [DUTY_W-1:0] r_min_duty;
    logic [DUTY_W-1:0] r_max_duty;
    logic [CFG_W-1:0]  r_rise_period;
    logic [CFG_W-1:0]  r_fall_period;

    // Controller state
    logic [DUTY_W-1:0]      r_target_duty, n_target_duty;
    logic [DUTY_W-1:0]      r_current_duty, n_current_duty;
    logic [PERIOD_BITS-1:0] r_countdown, n_countdown;
    logic                   r_armed, n_armed;

    // Output stage
    logic      r_out_valid;
    t_out_data r_out_data;
    logic      r_skid_valid;
    t_out_data r_skid_data;

    t_in_data  in_data;
    logic      in_xfer;
    logic      out_xfer;
    t_out_data result;

    // Update datapath
    logic              is_tick;
    logic              expire;
    logic              do_update;
    logic              keep_eff;
    logic              imm_eff;
    logic [DUTY_W-1:0] lo_lim, hi_lim;
    logic [REQ_W-1:0]  t_raw, t_lo, t_clamp;
    logic [REQ_W-1:0]  d_cur, d_up, d_down, d_new;
    logic              written;
    logic              arm_new;
    logic [CMP_W-1:0]  period_ext, period_lim, period_sat;

    assign in_data  = t_in_data'(s_axis_tdata);
    assign in_xfer  = s_axis_tvalid & s_axis_tready;
    assign out_xfer = r_out_valid & m_axis_tready;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = ~r_skid_valid;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = 16'(r_out_data);

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_duty    <= '0;
            r_max_duty    <= DUTY_CAP;
            r_rise_period <= 16'd500;
            r_fall_period <= 16'd2000;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_DUTY:    r_min_duty    <= i_cfg_data[DUTY_W-1:0];
                CFG_MAX_DUTY:    r_max_duty    <= i_cfg_data[DUTY_W-1:0];
                CFG_RISE_PERIOD: r_rise_period <= i_cfg_data;
                CFG_FALL_PERIOD: r_fall_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pick the operation: request, or tick that lets the countdown expire
    always_comb begin
        is_tick   = (s_axis_tuser == FUNC_TICK);
        expire    = is_tick & r_armed & (r_countdown <= PERIOD_BITS'(1));
        do_update = ~is_tick | expire;
        keep_eff  = is_tick ? 1'b1 : in_data.keep_target;
        imm_eff   = is_tick ? 1'b0 : in_data.immediate;
    end

    // Clamp the target: min first, then max
    always_comb begin
        lo_lim  = (r_min_duty > DUTY_CAP) ? DUTY_CAP : r_min_duty;
        hi_lim  = (r_max_duty > DUTY_CAP) ? DUTY_CAP : r_max_duty;
        t_raw   = keep_eff ? REQ_W'(r_target_duty) : in_data.target_percent;
        t_lo    = (t_raw < REQ_W'(lo_lim)) ? REQ_W'(lo_lim) : t_raw;
        t_clamp = (t_lo > REQ_W'(hi_lim)) ? REQ_W'(hi_lim) : t_lo;
    end

    // Step or jump the duty toward the target
    always_comb begin
        d_cur   = REQ_W'(r_current_duty);
        d_up    = ((d_cur + RAMP_STEP) > t_clamp) ? t_clamp : (d_cur + RAMP_STEP);
        d_down  = ((d_cur - t_clamp) > RAMP_STEP) ? (d_cur - RAMP_STEP) : t_clamp;
        written = do_update & (d_cur != t_clamp);
        if (imm_eff) begin
            d_new = t_clamp;
        end else if (d_cur < t_clamp) begin
            d_new = d_up;
        end else begin
            d_new = d_down;
        end
        arm_new = written & (d_new != t_clamp);
    end

    // Rearm period, saturated to what the countdown holds
    always_comb begin
        period_ext = (d_new > t_clamp) ? CMP_W'(r_fall_period) : CMP_W'(r_rise_period);
        period_lim = {CMP_W{1'b1}} >> (CMP_W - PERIOD_BITS);
        period_sat = (period_ext > period_lim) ? period_lim : period_ext;
    end

    // Next state
    always_comb begin
        n_target_duty  = do_update ? t_clamp[DUTY_W-1:0] : r_target_duty;
        n_current_duty = written ? d_new[DUTY_W-1:0] : r_current_duty;
        if (arm_new) begin
            n_armed     = 1'b1;
            n_countdown = period_sat[PERIOD_BITS-1:0];
        end else if (expire) begin
            n_armed     = 1'b0;
            n_countdown = '0;
        end else if (is_tick && r_armed) begin
            n_armed     = r_armed;
            n_countdown = r_countdown - PERIOD_BITS'(1);
        end else begin
            n_armed     = r_armed;
            n_countdown = r_countdown;
        end
        result.duty         = n_current_duty;
        result.target       = n_target_duty;
        result.duty_written = written;
        result.ramp_pending = n_armed;
    end

    // State registers advance on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_duty  <= '0;
            r_current_duty <= '0;
            r_countdown    <= '0;
            r_armed        <= 1'b0;
        end else if (in_xfer) begin
            r_target_duty  <= n_target_duty;
            r_current_duty <= n_current_duty;
            r_countdown    <= n_countdown;
            r_armed        <= n_armed;
        end
    end

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (in_xfer) begin
            if (!r_out_valid || out_xfer) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_xfer) begin
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            if (!r_out_valid || out_xfer) begin
                r_out_data <= result;
            end else begin
                r_skid_data <= result;
            end
        end else if (out_xfer && r_skid_valid) begin
            r_out_data <= r_skid_data;
        end
    end

`ifndef ASSERT_OFF
    // Skid entry only fills behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid without output entry");

    // Every input transfer is followed on the next cycle by a valid result on the master side
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
        else $error("input transfer produced no result");

    // An idle countdown is always cleared
    a_disarmed_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_armed |-> (r_countdown == '0))
        else $error("countdown nonzero while disarmed");

    // Driven duty never exceeds full scale
    a_duty_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[6:0] <= DUTY_CAP))
        else $error("duty above cap");
`endif

endmodule
